### src/rit_pkg.sv
// shared types, codes and the interval scaling function of the repeating interval timer
package rit_pkg;

  // opcodes of an input beat
  localparam logic [2:0] OP_CHECK  = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;

  // timer status codes
  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_PAUSED  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_MICROS   = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] time_now;
    logic [31:0] start_interval;
  } rit_in_t;

  typedef struct packed {
    logic        fired;
    logic        start_ok;
    logic [1:0]  timer_status;
    logic [31:0] run_count;
    logic [31:0] elapsed_time;
  } rit_out_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] last_fire_time;
    logic [31:0] paused_elapsed;
    logic [31:0] fire_count;
    logic [31:0] active_interval;
  } rit_state_t;

  typedef struct packed {
    logic [30:0] repeat_limit;
    logic        micros_mode;
  } rit_cfg_t;

  // in micros mode times 1000 modulo 2^32 as 1024 - 32 + 8, else the value unchanged
  function automatic logic [31:0] scale_interval(logic [31:0] v, logic micros);
    logic [31:0] prod;
    prod = (v << 10) - (v << 5) + (v << 3);
    return micros ? prod : v;
  endfunction

endpackage

### src/repeating_interval_timer.sv
// top level of the repeating interval timer with pause and resume
//
// usage
// - input channel: one beat per command, opcode check/start/stop/pause/resume
//   plus the time base value and an optional new interval for start
// - output channel: exactly one result beat per command, in order: fired flag,
//   start result, status after the command, run count and elapsed time
// - config port: plain write, index 0 interval, 1 repeat limit, 2 micros mode;
//   write only while no command is in flight
// - path: a taken command beat waits in the input register, then the step
//   logic writes the state and the result register that drives out_valid_o
// - throughput: one command per cycle while no output stall holds it; the
//   step logic updates the timer state register, so back to back commands
//   see each other's effect
// - a stall on the output holds the result register; the input register keeps
//   accepting until it is full, then in_stall_o rises
// - reset clears status, times, count and the config registers to zero
module repeating_interval_timer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rit_pkg::rit_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rit_pkg::rit_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rit_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rit_pkg::CfgDataW-1:0]        cfg_data_i
);

  // pipeline control
  logic                s1_valid_q, s1_valid_d;
  rit_pkg::rit_in_t    s1_data_q;
  logic                out_valid_q, out_valid_d;
  rit_pkg::rit_out_t   out_data_q;
  logic                out_free;
  logic                in_take;
  logic                s1_move;

  // config and timer state
  logic [31:0]         interval_q, interval_d;
  rit_pkg::rit_cfg_t   cfg_q, cfg_d;
  rit_pkg::rit_state_t state_q, state_d, step_state;
  rit_pkg::rit_out_t   step_result;

  // result register free when empty or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !out_free);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  rit_step u_step (
    .item_i   (s1_data_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (step_state),
    .result_o (step_result)
  );

  // interval and micros mode writes reload the active interval under the mode in force after the write
  always_comb begin
    interval_d = interval_q;
    cfg_d      = cfg_q;
    state_d    = s1_move ? step_state : state_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rit_pkg::CFG_INTERVAL: begin
          interval_d              = cfg_data_i;
          state_d.active_interval = rit_pkg::scale_interval(cfg_data_i, cfg_q.micros_mode);
        end
        rit_pkg::CFG_LIMIT: begin
          cfg_d.repeat_limit = cfg_data_i[30:0];
        end
        rit_pkg::CFG_MICROS: begin
          cfg_d.micros_mode       = cfg_data_i[0];
          state_d.active_interval = rit_pkg::scale_interval(interval_q, cfg_data_i[0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      interval_q  <= '0;
      cfg_q       <= '0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      interval_q  <= interval_d;
      cfg_q       <= cfg_d;
      state_q     <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (s1_move) begin
      out_data_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // input side only backs up behind a held result beat
  a_stall_needs_held_beat: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("input stalled without a held result beat");

  // a firing never leaves the timer paused
  a_fire_not_paused: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fired) |-> (out_data_o.timer_status != rit_pkg::ST_PAUSED)
  ) else $error("fired beat reports paused status");

  // fired and start_ok come from different commands
  a_fire_xor_start: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fired && out_data_o.start_ok)
  ) else $error("fired and start_ok set in one beat");

  // a beat handed to the step logic appears at the output next cycle
  a_step_to_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_move |=> out_valid_o
  ) else $error("stepped command produced no result beat");

endmodule

### src/rit_step.sv
// next timer state and result beat for one command
module rit_step (
  input  rit_pkg::rit_in_t    item_i,
  input  rit_pkg::rit_state_t state_i,
  input  rit_pkg::rit_cfg_t   cfg_i,
  output rit_pkg::rit_state_t state_o,
  output rit_pkg::rit_out_t   result_o
);

  logic [31:0] diff;
  logic [31:0] cnt_inc;
  logic [31:0] start_ai;
  logic        fired;
  logic        ok;

  assign diff     = item_i.time_now - state_i.last_fire_time;
  assign cnt_inc  = state_i.fire_count + 32'd1;
  assign start_ai = (item_i.start_interval != 32'd0)
                  ? rit_pkg::scale_interval(item_i.start_interval, cfg_i.micros_mode)
                  : state_i.active_interval;

  always_comb begin
    state_o = state_i;
    fired   = 1'b0;
    ok      = 1'b0;
    case (item_i.opcode)
      rit_pkg::OP_CHECK: begin
        if (state_i.status == rit_pkg::ST_RUNNING && diff >= state_i.active_interval) begin
          fired                  = 1'b1;
          state_o.fire_count     = cnt_inc;
          state_o.last_fire_time = item_i.time_now;
          if (cfg_i.repeat_limit != 31'd0 && cnt_inc >= {1'b0, cfg_i.repeat_limit}) begin
            state_o.status = rit_pkg::ST_STOPPED;
          end
        end
      end
      rit_pkg::OP_START: begin
        state_o.active_interval = start_ai;
        if (start_ai != 32'd0) begin
          ok = 1'b1;
          if (state_i.status != rit_pkg::ST_RUNNING) begin
            state_o.fire_count     = 32'd0;
            state_o.last_fire_time = item_i.time_now;
            state_o.status         = rit_pkg::ST_RUNNING;
          end
        end
      end
      rit_pkg::OP_STOP: begin
        state_o.status = rit_pkg::ST_STOPPED;
      end
      rit_pkg::OP_PAUSE: begin
        state_o.paused_elapsed = diff;
        state_o.status         = rit_pkg::ST_PAUSED;
      end
      rit_pkg::OP_RESUME: begin
        // a paused timer keeps the part of the interval already passed
        state_o.last_fire_time = (state_i.status == rit_pkg::ST_PAUSED)
                               ? item_i.time_now - state_i.paused_elapsed
                               : item_i.time_now;
        state_o.status         = rit_pkg::ST_RUNNING;
      end
      default: begin
      end
    endcase
  end

  assign result_o.fired        = fired;
  assign result_o.start_ok     = ok;
  assign result_o.timer_status = state_o.status;
  assign result_o.run_count    = state_o.fire_count;
  assign result_o.elapsed_time = item_i.time_now - state_o.last_fire_time;

endmodule

### tb/rit_tb_pkg.sv
`timescale 1ns / 100ps
// scoreboard class of the repeating interval timer testbench: timer prediction and result checks
package rit_tb_pkg;

  // opcodes five to seven have no function
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  // register index outside the map, must be ignored
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic [31:0] MICROS_SCALE = 32'd1000;

  class rit_scoreboard;

    // register copies
    logic [31:0] interval_reg;
    logic [30:0] limit_reg;
    logic        micros_reg;

    // timer state copies
    logic [1:0]  status;
    logic [31:0] last_fire;
    logic [31:0] paused_span;
    logic [31:0] fire_total;
    logic [31:0] active_ivl;

    rit_pkg::rit_out_t timer_results_q[$];
    int unsigned       error_count;

    function new();
      interval_reg = '0;
      limit_reg    = '0;
      micros_reg   = 1'b0;
      status       = rit_pkg::ST_STOPPED;
      last_fire    = '0;
      paused_span  = '0;
      fire_total   = '0;
      active_ivl   = '0;
      error_count  = 0;
    endfunction

    function logic [31:0] scaled(logic [31:0] v);
      return micros_reg ? v * MICROS_SCALE : v;
    endfunction

    function int pending();
      return timer_results_q.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        rit_pkg::CFG_INTERVAL: begin
          interval_reg = val;
          active_ivl   = scaled(interval_reg);
        end
        rit_pkg::CFG_LIMIT: begin
          limit_reg = val[30:0];
        end
        rit_pkg::CFG_MICROS: begin
          micros_reg = val[0];
          active_ivl = scaled(interval_reg);
        end
        default: begin
        end
      endcase
    endfunction

    // advance the timer copy by one accepted command beat
    function void note_command(rit_pkg::rit_in_t cmd);
      rit_pkg::rit_out_t res;
      res = '0;
      case (cmd.opcode)
        rit_pkg::OP_CHECK: begin
          if (status == rit_pkg::ST_RUNNING && (cmd.time_now - last_fire) >= active_ivl) begin
            res.fired  = 1'b1;
            fire_total = fire_total + 32'd1;
            last_fire  = cmd.time_now;
            if (limit_reg != '0 && fire_total >= {1'b0, limit_reg}) begin
              status = rit_pkg::ST_STOPPED;
            end
          end
        end
        rit_pkg::OP_START: begin
          if (cmd.start_interval != '0) active_ivl = scaled(cmd.start_interval);
          if (active_ivl != '0) begin
            res.start_ok = 1'b1;
            if (status != rit_pkg::ST_RUNNING) begin
              fire_total = '0;
              last_fire  = cmd.time_now;
              status     = rit_pkg::ST_RUNNING;
            end
          end
        end
        rit_pkg::OP_STOP: begin
          status = rit_pkg::ST_STOPPED;
        end
        rit_pkg::OP_PAUSE: begin
          paused_span = cmd.time_now - last_fire;
          status      = rit_pkg::ST_PAUSED;
        end
        rit_pkg::OP_RESUME: begin
          last_fire = (status == rit_pkg::ST_PAUSED) ? cmd.time_now - paused_span
                                                     : cmd.time_now;
          status    = rit_pkg::ST_RUNNING;
        end
        default: begin
        end
      endcase
      res.timer_status = status;
      res.run_count    = fire_total;
      res.elapsed_time = cmd.time_now - last_fire;
      timer_results_q.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task check_result(rit_pkg::rit_out_t got);
      rit_pkg::rit_out_t want;
      if (timer_results_q.size() == 0) begin
        report("unexpected result beat", 32'({got.fired, got.start_ok, got.timer_status}),
               32'd0);
      end else begin
        want = timer_results_q.pop_front();
        if (got.fired !== want.fired) report("fired", 32'(got.fired), 32'(want.fired));
        if (got.start_ok !== want.start_ok)
          report("start_ok", 32'(got.start_ok), 32'(want.start_ok));
        if (got.timer_status !== want.timer_status)
          report("timer_status", 32'(got.timer_status), 32'(want.timer_status));
        if (got.run_count !== want.run_count)
          report("run_count", got.run_count, want.run_count);
        if (got.elapsed_time !== want.elapsed_time)
          report("elapsed_time", got.elapsed_time, want.elapsed_time);
      end
    endtask

  endclass

endpackage

### tb/tb_repeating_interval_timer.sv
`timescale 1ns / 100ps
// top level testbench of the repeating interval timer: directed and random command beats
module tb_repeating_interval_timer;

  // cycles without any beat before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // pause after a drain; a result passes the input register and then the result register
  localparam int unsigned SETTLE_CYCLES = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  rit_pkg::rit_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  rit_pkg::rit_out_t out_data_o;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [31:0]       cfg_data_i;

  rit_tb_pkg::rit_scoreboard sb;

  // percent of cycles in which the sender idles and the receiver stalls
  int unsigned idle_pct;
  int unsigned stall_pct;
  // free running time base as seen by the command source
  logic [31:0] timebase;
  int unsigned quiet_cycles = 0;

  repeating_interval_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // receiver side: random stall, independent of valid
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // result checks and the hang watchdog; values sampled here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one command beat: optional idle cycles, then hold until accepted
  task automatic send(rit_pkg::rit_in_t cmd);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd);
  endtask

  task automatic issue(logic [2:0] op, logic [31:0] at, logic [31:0] ivl);
    rit_pkg::rit_in_t cmd;
    cmd.opcode         = op;
    cmd.time_now       = at;
    cmd.start_interval = ivl;
    send(cmd);
  endtask

  // register write; the caller lowers the write enable after the last one
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // registers change only with nothing in flight
  task automatic load_settings(logic [31:0] ivl, logic [30:0] limit, logic micros,
                               bit poke_spare);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(rit_pkg::CFG_INTERVAL, ivl);
    write_reg(rit_pkg::CFG_LIMIT, {1'b0, limit});
    write_reg(rit_pkg::CFG_MICROS, {31'b0, micros});
    if (poke_spare) write_reg(rit_tb_pkg::CFG_SPARE, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  // short hand written sequence on reset settings (interval zero, endless, millis)
  task automatic directed_cmds();
    idle_pct  = 0;
    stall_pct = 0;
    issue(rit_pkg::OP_CHECK, 32'd0, 32'd0);                  // check while stopped
    issue(rit_pkg::OP_START, 32'd5, 32'd0);                  // start with zero interval fails
    issue(rit_tb_pkg::OP_FIRST_UNUSED, 32'd6, 32'hFFFF_FFFF); // spare opcodes do nothing
    issue(rit_tb_pkg::OP_FIRST_UNUSED + 3'd1, 32'd7, 32'd0);
    issue(rit_tb_pkg::OP_FIRST_UNUSED + 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(rit_pkg::OP_RESUME, 32'd10, 32'd0);                // resume from stopped
    issue(rit_pkg::OP_CHECK, 32'd10, 32'd0);                 // zero interval fires every check
    issue(rit_pkg::OP_CHECK, 32'd11, 32'd0);
    issue(rit_pkg::OP_START, 32'd12, 32'd10);                // start while running keeps count
    issue(rit_pkg::OP_CHECK, 32'd15, 32'd0);
    issue(rit_pkg::OP_CHECK, 32'd21, 32'd0);
    issue(rit_pkg::OP_PAUSE, 32'd25, 32'd0);
    issue(rit_pkg::OP_CHECK, 32'd100, 32'd0);                // paused, no firing
    issue(rit_pkg::OP_RESUME, 32'd200, 32'd0);               // resume keeps the elapsed part
    issue(rit_pkg::OP_CHECK, 32'd206, 32'd0);
    issue(rit_pkg::OP_STOP, 32'd300, 32'd0);
    issue(rit_pkg::OP_PAUSE, 32'd301, 32'd0);                // pause from stopped
    issue(rit_pkg::OP_RESUME, 32'd302, 32'd0);
    issue(rit_pkg::OP_START, 32'd303, 32'hFFFF_FFFF);        // widest interval while running
    issue(rit_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd0);
    issue(rit_pkg::OP_STOP, 32'hFFFF_FFF0, 32'd0);
    issue(rit_pkg::OP_START, 32'hFFFF_FFF0, 32'd4);
    issue(rit_pkg::OP_CHECK, 32'h0000_0002, 32'd0);          // difference across the wrap
    issue(rit_pkg::OP_CHECK, 32'h8000_0000, 32'd0);
    in_valid_i <= 1'b0;
  endtask

  // random commands: mostly checks on a moving time base, with starts, stops, pauses and
  // resumes to keep the timer cycling, and some spare opcodes and time jumps as noise
  task automatic random_cmds(int unsigned n_items, int unsigned idle_in,
                             int unsigned stall_in, int unsigned span,
                             int unsigned ivl_max, bit hold_mid);
    int unsigned pick;
    logic [2:0]  op;
    logic [31:0] ivl;
    idle_pct  = idle_in;
    stall_pct = stall_in;
    timebase  = $urandom();
    for (int unsigned i = 0; i < n_items; i++) begin
      // sender waits for every result once, halfway through
      if (hold_mid && i == n_items / 2) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 62) op = rit_pkg::OP_CHECK;
      else if (pick < 72) op = rit_pkg::OP_START;
      else if (pick < 77) op = rit_pkg::OP_STOP;
      else if (pick < 85) op = rit_pkg::OP_PAUSE;
      else if (pick < 96) op = rit_pkg::OP_RESUME;
      else op = rit_tb_pkg::OP_FIRST_UNUSED + 3'($urandom_range(0, 2));
      // start interval: keep current, a small one, or any value
      ivl = $urandom();
      if (op == rit_pkg::OP_START) begin
        pick = $urandom_range(99);
        if (pick < 40) ivl = '0;
        else if (pick < 92) ivl = $urandom_range(1, ivl_max);
      end
      if ($urandom_range(99) < 2) timebase = $urandom();
      else timebase = timebase + $urandom_range(0, span);
      issue(op, timebase, ivl);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    sb           = new();
    idle_pct     = 0;
    stall_pct    = 0;
    timebase     = '0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_cmds();

    // short auto stop, no idling
    load_settings(32'd5, 31'd3, 1'b0, 1'b0);
    random_cmds(300, 0, 0, 4, 12, 1'b0);
    // endless repeat, sender idles, one full drain
    load_settings(32'd20, 31'd0, 1'b0, 1'b0);
    random_cmds(300, 59, 0, 15, 40, 1'b1);
    // micros mode, single firing, receiver stalls
    load_settings(32'd3, 31'd1, 1'b1, 1'b0);
    random_cmds(300, 0, 59, 1500, 6, 1'b0);
    // widest register values, both sides idle, spare register index poked
    load_settings(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1);
    random_cmds(300, 38, 38, 3000, 8, 1'b0);
    // zero default interval, starts often fail
    load_settings(32'd0, 31'd2, 1'b0, 1'b0);
    random_cmds(300, 59, 59, 6, 10, 1'b0);
    // back to micros with a moderate limit, no idling
    load_settings(32'd9, 31'd4, 1'b1, 1'b0);
    random_cmds(300, 0, 0, 4000, 12, 1'b0);

    // drain, then give the block time to show any stray beat
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results never arrived", 32'(sb.pending()), 32'd0);
    if (sb.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### repeating_interval_timer.f
src/rit_pkg.sv
src/rit_step.sv
src/repeating_interval_timer.sv
tb/rit_tb_pkg.sv
tb/tb_repeating_interval_timer.sv
